// ===== sv/cit_pkg.sv =====
// Shared types and constants of the cascaded interval timer.
`default_nettype none
package cit_pkg;

  localparam int CTRL_W = 12;

  // Request actions.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_CTRL0  = 3'd0;
  localparam logic [2:0] REG_LOAD0  = 3'd1;
  localparam logic [2:0] REG_COUNT0 = 3'd2;
  localparam logic [2:0] REG_CTRL1  = 3'd3;
  localparam logic [2:0] REG_LOAD1  = 3'd4;
  localparam logic [2:0] REG_COUNT1 = 3'd5;

  // Control word bits.
  localparam logic [CTRL_W-1:0] CTRL_DOWN    = 12'h002;
  localparam logic [CTRL_W-1:0] CTRL_RELOAD  = 12'h010;
  localparam logic [CTRL_W-1:0] CTRL_LOAD    = 12'h020;
  localparam logic [CTRL_W-1:0] CTRL_INTEN   = 12'h040;
  localparam logic [CTRL_W-1:0] CTRL_ENABLE  = 12'h080;
  localparam logic [CTRL_W-1:0] CTRL_INT     = 12'h100;
  localparam logic [CTRL_W-1:0] CTRL_CASCADE = 12'h800;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
  } cit_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
  } cit_rsp_t;

endpackage
`default_nettype wire

// ===== sv/cit_core.sv =====
// Timer state registers and the single-step update for one request.
`default_nettype none
module cit_core import cit_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step_en,
  input  wire cit_req_t req,
  output cit_rsp_t      rsp
);

  logic [CTRL_W-1:0] ctrl_low_r, ctrl_low_nxt;
  logic [CTRL_W-1:0] ctrl_high_r, ctrl_high_nxt;
  logic [31:0]       load_low_r, load_low_nxt;
  logic [31:0]       load_high_r, load_high_nxt;
  logic [63:0]       count_r, count_nxt;

  logic        loading;
  logic        counting;
  logic        count_down;
  logic        rolled;
  logic [63:0] count_step;
  logic [63:0] count_mid;
  logic [CTRL_W-1:0] flag;

  assign loading    = ((ctrl_low_r & CTRL_LOAD) != '0) || ((ctrl_high_r & CTRL_LOAD) != '0);
  assign counting   = ((ctrl_low_r & CTRL_ENABLE) != '0) && !loading;
  assign count_down = (ctrl_low_r & CTRL_DOWN) != '0;
  assign rolled     = count_down ? (count_r == '0) : (count_r == '1);
  assign count_step = count_down ? (count_r - 64'd1) : (count_r + 64'd1);

  always_comb begin
    ctrl_low_nxt  = ctrl_low_r;
    ctrl_high_nxt = ctrl_high_r;
    load_low_nxt  = load_low_r;
    load_high_nxt = load_high_r;
    count_mid     = count_r;
    flag          = ctrl_low_r & CTRL_INT;
    unique case (req.action)
      ACT_TICK: begin
        if (counting) begin
          count_mid = count_step;
          if (rolled) begin
            ctrl_low_nxt = ctrl_low_r | CTRL_INT;
            if ((ctrl_low_r & CTRL_RELOAD) != '0) begin
              count_mid = {load_high_r, load_low_r};
            end
          end
        end
      end
      ACT_WRITE: begin
        unique case (req.reg_index)
          REG_CTRL0: begin
            // Writing one to the flag clears it; writing zero keeps it.
            if ((req.write_data[CTRL_W-1:0] & CTRL_INT) != '0) begin
              flag = '0;
            end
            ctrl_low_nxt = (req.write_data[CTRL_W-1:0] & ~CTRL_INT) | flag;
          end
          REG_LOAD0: load_low_nxt = req.write_data;
          REG_CTRL1: ctrl_high_nxt = req.write_data[CTRL_W-1:0] & ~CTRL_INT;
          REG_LOAD1: load_high_nxt = req.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
    // A set load bit keeps its half of the counter following the load register.
    count_nxt = count_mid;
    if ((ctrl_low_nxt & CTRL_LOAD) != '0) begin
      count_nxt[31:0] = load_low_nxt;
    end
    if ((ctrl_high_nxt & CTRL_LOAD) != '0) begin
      count_nxt[63:32] = load_high_nxt;
    end
  end

  always_comb begin
    rsp.read_data = '0;
    if (req.action == ACT_READ) begin
      unique case (req.reg_index)
        REG_CTRL0:  rsp.read_data = {{(32-CTRL_W){1'b0}}, ctrl_low_r};
        REG_LOAD0:  rsp.read_data = load_low_r;
        REG_COUNT0: rsp.read_data = count_r[31:0];
        REG_CTRL1:  rsp.read_data = {{(32-CTRL_W){1'b0}}, ctrl_high_r};
        REG_LOAD1:  rsp.read_data = load_high_r;
        REG_COUNT1: rsp.read_data = count_r[63:32];
        default:    rsp.read_data = '0;
      endcase
    end
    rsp.irq = ((ctrl_low_nxt & CTRL_INT) != '0) && ((ctrl_low_nxt & CTRL_INTEN) != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_low_r  <= '0;
      ctrl_high_r <= '0;
      load_low_r  <= '0;
      load_high_r <= '0;
      count_r     <= '0;
    end else if (step_en) begin
      ctrl_low_r  <= ctrl_low_nxt;
      ctrl_high_r <= ctrl_high_nxt;
      load_low_r  <= load_low_nxt;
      load_high_r <= load_high_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/cascaded_interval_timer.sv =====
// Top level of the cascaded 64-bit interval timer: request and result registers.
//
// Each request on the in_ channel is a clock tick, a register write or a register
// read; every request yields exactly one result on the out_ channel carrying the
// read data (zero unless a read) and the interrupt line after that request.
// A request is taken when in_valid is high and in_stall is low, and a result when
// out_valid is high and out_stall is low.
// The request first waits in the request register; the state update and result are then
// formed from it and land in the result register.
// Throughput is one request per cycle while out_stall is low; the 64-bit count update
// is a single increment or decrement with an all-ones or zero compare in that cycle.
// While the receiver stalls, the result register holds its value and one more
// request may wait in the request register; after that in_stall rises.
// Synchronous reset clears all control words, load registers and the counter
// and empties both registers.
`default_nettype none
module cascaded_interval_timer import cit_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire cit_req_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cit_rsp_t      out_data
);

  logic     req_vld_r;
  cit_req_t req_r;
  logic     rsp_vld_r;
  cit_rsp_t rsp_r;
  cit_rsp_t rsp_nxt;
  logic     advance;

  // The held request moves on whenever the result register is free or draining.
  assign advance  = req_vld_r && (!rsp_vld_r || !out_stall);
  assign in_stall = req_vld_r && !advance;

  cit_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .req     (req_r),
    .rsp     (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_vld_r <= in_valid;
      end
      if (advance) begin
        rsp_vld_r <= 1'b1;
      end else if (!out_stall) begin
        rsp_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_data;
    end
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = rsp_vld_r;
  assign out_data  = rsp_r;

endmodule
`default_nettype wire
